FILE: rtl/evt_pkg.sv
// evt_pkg: shared types, constants and helpers of the encoder tracker
// no dependencies; used by the datapath, the divider, the controller and the top level
package evt_pkg;

    localparam int POS_W     = 48;
    localparam int FRAC_BITS = 16;
    localparam int FACT_W    = 32;
    localparam int TIME_W    = 32;
    localparam int PULSE_W   = 16;
    localparam int DVD_W     = 64;
    localparam int DVS_W     = 32;
    localparam int HALF_W    = POS_W / 2;
    localparam int PROD_W    = HALF_W + FACT_W;
    localparam int ACC_W     = POS_W + FACT_W;
    localparam int DIFF_W    = POS_W + 1;
    localparam int VEL_W     = 60;

    // pwm position: m * 2^16 / 1023 = 64*m + floor(64*m / 1023)
    // floor(y / 1023) for y < 2^22 is (y * ceil(2^32 / 1023)) >> 32
    localparam int PWM_Y_W    = PULSE_W + 6;
    localparam int PWM_K_W    = 23;
    localparam int PWM_PROD_W = PWM_Y_W + PWM_K_W;
    localparam int PWM_SHIFT  = 32;
    localparam logic [PWM_K_W-1:0] PWM_RECIP = 23'd4198405;

    localparam logic signed [VEL_W-1:0] VEL_SCALE = 60'sd1000;
    localparam logic signed [DIFF_W-1:0] ONE_FX = 49'sd1 <<< FRAC_BITS;
    localparam logic signed [POS_W-1:0] MAX48 = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] MIN48 = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [DVD_W-1:0] MAX_MAG = 64'd1 << (POS_W - 1);

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_INVERT = 2'd1;
    localparam logic [1:0] REG_PFACT  = 2'd2;
    localparam logic [1:0] REG_VFACT  = 2'd3;

    localparam logic [1:0] MODE_QUAD = 2'd1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DT_ZERO = 2'd1;
    localparam logic [1:0] STAT_PF_ZERO = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_POS_DIV,
        OP_POS_SET,
        OP_QUAD,
        OP_PWM,
        OP_VEL_DIV,
        OP_VEL_SET,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_MUL_ACC,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_POS_DIV,
        ST_POS_WAIT,
        ST_POS_SET,
        ST_QUAD,
        ST_PWM,
        ST_VEL_DIV,
        ST_VEL_WAIT,
        ST_VEL_SET,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_MUL_ACC,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_vel;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd_set;
        logic quad;
        logic pf_zero;
        logic dt_zero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    // apply sign to a magnitude and clamp to the 48-bit range
    function automatic logic signed [POS_W-1:0] sat_apply(input logic [DVD_W-1:0] q,
                                                          input logic neg);
        logic signed [POS_W-1:0] r;
        r = $signed(q[POS_W-1:0]);
        if (q >= MAX_MAG)
            return neg ? MIN48 : MAX48;
        return neg ? -r : r;
    endfunction

    function automatic logic [POS_W-1:0] mag48(input logic signed [POS_W-1:0] x);
        return x[POS_W-1] ? POS_W'(-x) : POS_W'(x);
    endfunction

    function automatic logic [FACT_W-1:0] mag32(input logic signed [FACT_W-1:0] x);
        return x[FACT_W-1] ? FACT_W'(-x) : FACT_W'(x);
    endfunction

endpackage

FILE: rtl/evt_if.sv
// evt_in_if / evt_out_if: valid-ready channels of the encoder tracker
// standalone, no package needed
interface evt_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [15:0]        pulse_high_us;
    logic               b_level;
    logic [31:0]        time_ms;
    logic signed [47:0] new_position;

    modport source (output valid, command, pulse_high_us, b_level, time_ms, new_position,
                    input ready);
    modport sink (input valid, command, pulse_high_us, b_level, time_ms, new_position,
                  output ready);
endinterface

interface evt_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] scaled_position;
    logic signed [47:0] scaled_velocity;
    logic [1:0]         status;

    modport source (output valid, scaled_position, scaled_velocity, status, input ready);
    modport sink (input valid, scaled_position, scaled_velocity, status, output ready);
endinterface

FILE: rtl/encoder_position_velocity_tracker.sv
// encoder_position_velocity_tracker: encoder position and velocity tracker, top level
// a sample update skips the velocity divide when the elapsed time is zero
// set position skips the position divide when the position factor is zero
// one request at a time; a new request is taken in the cycle after the result is
// registered; the 64-step serial velocity divide dominates a sample update
// rst_n async active low: factors to 1.0, mode 0, position/velocity/time to zero
module encoder_position_velocity_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    evt_in_if.sink      in_ch,
    evt_out_if.source   out_ch
);
    import evt_pkg::*;

    // command and status between the sequencer and the datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: accepts a request in idle, then position update and divide, scale, output
    evt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: config registers, state, shared divider, split multiplier,
    // output register that lets a new request start while a result waits
    evt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cmd       (cmd),
        .stat      (stat)
    );
endmodule

FILE: rtl/evt_div.sv
// evt_div: restoring unsigned divider, one quotient bit per cycle
// depends on evt_pkg
module evt_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [evt_pkg::DVD_W-1:0] dividend,
    input  logic [evt_pkg::DVS_W-1:0] divisor,
    output logic [evt_pkg::DVD_W-1:0] quotient,
    output logic                      done
);
    import evt_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;
endmodule

FILE: rtl/evt_dp.sv
// evt_dp: registers, configuration, arithmetic and output stage of the tracker
// depends on evt_pkg, evt_if and evt_div
module evt_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_data,
    evt_in_if.sink                     in_ch,
    evt_out_if.source                  out_ch,
    input  evt_pkg::dp_cmd_t           cmd,
    output evt_pkg::dp_stat_t          stat
);
    import evt_pkg::*;

    // configuration
    logic [1:0]               mode_reg;
    logic                     invert_reg;
    logic signed [FACT_W-1:0] pfact_reg;
    logic signed [FACT_W-1:0] vfact_reg;

    // tracker state
    logic signed [POS_W-1:0]  raw_pos_reg;
    logic signed [POS_W-1:0]  prev_pos_reg;
    logic [TIME_W-1:0]        prev_time_reg;
    logic signed [POS_W-1:0]  raw_vel_reg;

    // captured request
    logic                     cmd_set_reg;
    logic [PULSE_W-1:0]       pulse_reg;
    logic                     b_reg;
    logic [TIME_W-1:0]        time_reg;
    logic signed [POS_W-1:0]  target_reg;

    logic                     div_neg_reg;
    logic [1:0]               status_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic signed [POS_W-1:0]  spos_reg;
    logic signed [POS_W-1:0]  svel_reg;

    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  out_pos_reg;
    logic signed [POS_W-1:0]  out_vel_reg;
    logic [1:0]               out_status_reg;

    logic                     div_start;
    logic [DVD_W-1:0]         div_dividend;
    logic [DVS_W-1:0]         div_divisor;
    logic                     div_neg;
    logic [DVD_W-1:0]         div_quot;
    logic                     div_done;

    logic [TIME_W-1:0]        dt;
    logic signed [DIFF_W-1:0] pos_diff;
    logic signed [VEL_W-1:0]  vel_num;
    logic signed [DIFF_W-1:0] quad_sum;
    logic signed [POS_W-1:0]  quad_next;
    logic [PULSE_W-1:0]       pulse_mag;

    logic [PWM_Y_W-1:0]       pwm_scaled;
    logic [PWM_PROD_W-1:0]    pwm_prod;
    logic [POS_W-1:0]         pwm_mag;
    logic signed [POS_W-1:0]  pwm_pos;

    logic signed [POS_W-1:0]  mul_a;
    logic signed [FACT_W-1:0] mul_f;
    logic [POS_W-1:0]         mul_amag;
    logic [FACT_W-1:0]        mul_fmag;
    logic [HALF_W-1:0]        mul_half;
    logic                     mul_neg;
    logic [ACC_W-1:0]         mul_sum;
    logic [ACC_W-1:0]         mul_shift;
    logic [DVD_W-1:0]         mul_q;
    logic signed [POS_W-1:0]  mul_res;

    assign dt       = time_reg - prev_time_reg;
    assign pos_diff = DIFF_W'(raw_pos_reg) - DIFF_W'(prev_pos_reg);
    assign vel_num  = VEL_W'(pos_diff) * VEL_SCALE;

    assign quad_sum  = (b_reg ^ invert_reg) ? DIFF_W'(raw_pos_reg) + ONE_FX
                                            : DIFF_W'(raw_pos_reg) - ONE_FX;
    assign quad_next = (quad_sum > DIFF_W'(MAX48)) ? MAX48
                     : (quad_sum < DIFF_W'(MIN48)) ? MIN48 : quad_sum[POS_W-1:0];

    // pulse of zero gives minus one before the divide
    assign pulse_mag = (pulse_reg == '0) ? PULSE_W'(1) : pulse_reg - 1'b1;

    // divide by 1023 through a reciprocal, truncated toward zero
    assign pwm_scaled = {pulse_mag, 6'd0};
    assign pwm_prod   = PWM_PROD_W'(pwm_scaled) * PWM_PROD_W'(PWM_RECIP);
    assign pwm_mag    = POS_W'(pwm_scaled) + POS_W'(pwm_prod[PWM_PROD_W-1:PWM_SHIFT]);
    assign pwm_pos    = (pulse_reg == '0) ? -$signed(pwm_mag) : $signed(pwm_mag);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_neg      = 1'b0;
        case (cmd.op)
            OP_POS_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(mag48(target_reg)) << FRAC_BITS;
                div_divisor  = mag32(pfact_reg);
                div_neg      = target_reg[POS_W-1] ^ pfact_reg[FACT_W-1];
            end
            OP_VEL_DIV:
            begin
                div_start    = (dt != '0);
                div_dividend = DVD_W'(vel_num[VEL_W-1] ? -vel_num : vel_num);
                div_divisor  = dt;
                div_neg      = vel_num[VEL_W-1];
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    evt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    // scaling: 24-bit halves of the magnitude times the factor magnitude
    assign mul_a     = cmd.sel_vel ? raw_vel_reg : raw_pos_reg;
    assign mul_f     = cmd.sel_vel ? vfact_reg : pfact_reg;
    assign mul_amag  = mag48(mul_a);
    assign mul_fmag  = mag32(mul_f);
    assign mul_neg   = mul_a[POS_W-1] ^ mul_f[FACT_W-1];
    assign mul_half  = (cmd.op == OP_MUL_HI) ? mul_amag[POS_W-1:HALF_W]
                                             : mul_amag[HALF_W-1:0];
    assign mul_sum   = acc_reg + ACC_W'(prod_reg);
    assign mul_shift = mul_sum >> FRAC_BITS;
    assign mul_q     = (|mul_shift[ACC_W-1:POS_W-1]) ? MAX_MAG : DVD_W'(mul_shift[POS_W-2:0]);
    assign mul_res   = sat_apply(mul_q, mul_neg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            invert_reg    <= 1'b0;
            pfact_reg     <= FACT_W'(ONE_FX);
            vfact_reg     <= FACT_W'(ONE_FX);
            raw_pos_reg   <= '0;
            prev_pos_reg  <= '0;
            prev_time_reg <= '0;
            raw_vel_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[1:0];
                    REG_INVERT: invert_reg <= cfg_data[0];
                    REG_PFACT:  pfact_reg  <= $signed(cfg_data);
                    REG_VFACT:  vfact_reg  <= $signed(cfg_data);
                    default:    mode_reg   <= mode_reg;
                endcase
            end
            case (cmd.op)
                OP_POS_SET: raw_pos_reg <= sat_apply(div_quot, div_neg_reg);
                OP_QUAD:    raw_pos_reg <= quad_next;
                OP_PWM:     raw_pos_reg <= pwm_pos;
                OP_VEL_DIV:
                begin
                    prev_pos_reg  <= raw_pos_reg;
                    prev_time_reg <= time_reg;
                end
                OP_VEL_SET: raw_vel_reg <= sat_apply(div_quot, div_neg_reg);
                default:    raw_pos_reg <= raw_pos_reg;
            endcase
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                cmd_set_reg <= in_ch.command;
                pulse_reg   <= in_ch.pulse_high_us;
                b_reg       <= in_ch.b_level;
                time_reg    <= in_ch.time_ms;
                target_reg  <= in_ch.new_position;
                status_reg  <= (in_ch.command && pfact_reg == '0) ? STAT_PF_ZERO : STAT_OK;
            end
            OP_POS_DIV: div_neg_reg <= div_neg;
            OP_VEL_DIV:
            begin
                div_neg_reg <= div_neg;
                if (dt == '0)
                    status_reg <= STAT_DT_ZERO;
            end
            OP_MUL_HI:
            begin
                prod_reg <= PROD_W'(mul_half) * PROD_W'(mul_fmag);
                acc_reg  <= '0;
            end
            OP_MUL_LO:
            begin
                prod_reg <= PROD_W'(mul_half) * PROD_W'(mul_fmag);
                acc_reg  <= ACC_W'(prod_reg) << HALF_W;
            end
            OP_MUL_ACC:
            begin
                if (cmd.sel_vel)
                    svel_reg <= mul_res;
                else
                    spos_reg <= mul_res;
            end
            OP_OUT:
            begin
                out_pos_reg    <= spos_reg;
                out_vel_reg    <= svel_reg;
                out_status_reg <= status_reg;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.scaled_position = out_pos_reg;
    assign out_ch.scaled_velocity = out_vel_reg;
    assign out_ch.status          = out_status_reg;

    assign stat.cmd_set  = cmd_set_reg;
    assign stat.quad     = (mode_reg == MODE_QUAD);
    assign stat.pf_zero  = (pfact_reg == '0);
    assign stat.dt_zero  = (dt == '0);
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ch.ready;
endmodule

FILE: rtl/evt_ctrl.sv
// evt_ctrl: sequencing state machine of the tracker
// depends on evt_pkg; drives the datapath through dp_cmd_t
module evt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  evt_pkg::dp_stat_t stat,
    output evt_pkg::dp_cmd_t  cmd
);
    import evt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        vel_reg;
    logic        vel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vel_reg   <= vel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        vel_next   = vel_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                vel_next = 1'b0;
                if (stat.cmd_set)
                    state_next = stat.pf_zero ? ST_MUL_HI : ST_POS_DIV;
                else
                    state_next = stat.quad ? ST_QUAD : ST_PWM;
            end
            ST_POS_DIV:  state_next = ST_POS_WAIT;
            ST_POS_WAIT:
                if (stat.div_done)
                    state_next = ST_POS_SET;
            ST_POS_SET:  state_next = ST_MUL_HI;
            ST_QUAD:     state_next = ST_VEL_DIV;
            ST_PWM:      state_next = ST_VEL_DIV;
            ST_VEL_DIV:  state_next = stat.dt_zero ? ST_MUL_HI : ST_VEL_WAIT;
            ST_VEL_WAIT:
                if (stat.div_done)
                    state_next = ST_VEL_SET;
            ST_VEL_SET:  state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_ACC;
            ST_MUL_ACC:
            begin
                vel_next   = 1'b1;
                state_next = vel_reg ? ST_OUT : ST_MUL_HI;
            end
            ST_OUT:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.sel_vel = vel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            ST_POS_DIV:  cmd.op = OP_POS_DIV;
            ST_POS_SET:  cmd.op = OP_POS_SET;
            ST_QUAD:     cmd.op = OP_QUAD;
            ST_PWM:      cmd.op = OP_PWM;
            ST_VEL_DIV:  cmd.op = OP_VEL_DIV;
            ST_VEL_SET:  cmd.op = OP_VEL_SET;
            ST_MUL_HI:   cmd.op = OP_MUL_HI;
            ST_MUL_LO:   cmd.op = OP_MUL_LO;
            ST_MUL_ACC:  cmd.op = OP_MUL_ACC;
            ST_OUT:
                if (stat.out_free)
                    cmd.op = OP_OUT;
            default:     cmd.op = OP_NONE;
        endcase
    end
endmodule

FILE: test/tb.sv
// tb: self-checking testbench of encoder_position_velocity_tracker
// needs rtl/evt_pkg.sv, rtl/evt_if.sv and the tracker rtl
module tb;
    import evt_pkg::*;

    // expected result of one request
    typedef struct {
        logic signed [47:0] spos;
        logic signed [47:0] svel;
        logic [1:0]         stat;
    } track_out_t;

    // tracker predictor plus the queue of results still to come
    class track_board;
        logic [1:0]         mode;
        logic               inv;
        logic signed [31:0] pfact;
        logic signed [31:0] vfact;
        logic signed [63:0] pos;
        logic signed [63:0] prev_pos;
        logic [31:0]        prev_t;
        logic signed [63:0] vel;
        track_out_t         pending[$];
        int                 errors;
        int                 checked;

        function new();
            mode = 0;
            inv = 0;
            pfact = 32'sd65536;
            vfact = 32'sd65536;
            pos = 0;
            prev_pos = 0;
            prev_t = 0;
            vel = 0;
            errors = 0;
            checked = 0;
        endfunction

        function logic signed [63:0] clamp48(input logic signed [63:0] x);
            if (x > 64'sh7FFF_FFFF_FFFF)
                return 64'sh7FFF_FFFF_FFFF;
            if (x < -64'sh8000_0000_0000)
                return -64'sh8000_0000_0000;
            return x;
        endfunction

        // (a*f) >> 16 toward zero, saturated; 128-bit product avoids overflow
        function logic signed [63:0] scale(input logic signed [63:0] a,
                                           input logic signed [31:0] f);
            logic [127:0] ma;
            logic [127:0] mf;
            logic [127:0] p;
            logic         neg;
            neg = (a < 0) != (f < 0);
            ma = a < 0 ? 128'(-a) : 128'(a);
            mf = f < 0 ? 128'(-64'(f)) : 128'(64'(f));
            p = (ma * mf) >> FRAC_BITS;
            if (neg)
                return p >= 128'h8000_0000_0000 ? -64'sh8000_0000_0000 : -$signed(64'(p));
            return p > 128'h7FFF_FFFF_FFFF ? 64'sh7FFF_FFFF_FFFF : $signed(64'(p));
        endfunction

        // (n << 16) / d toward zero, saturated
        function logic signed [63:0] divide(input logic signed [63:0] n,
                                            input logic signed [31:0] d);
            logic [127:0] mn;
            logic [127:0] md;
            logic [127:0] q;
            logic         neg;
            neg = (n < 0) != (d < 0);
            mn = n < 0 ? 128'(-n) : 128'(n);
            md = d < 0 ? 128'(-64'(d)) : 128'(64'(d));
            q = (mn << FRAC_BITS) / md;
            if (neg)
                return q >= 128'h8000_0000_0000 ? -64'sh8000_0000_0000 : -$signed(64'(q));
            return q > 128'h7FFF_FFFF_FFFF ? 64'sh7FFF_FFFF_FFFF : $signed(64'(q));
        endfunction

        function void configure(input logic [1:0] idx, input logic [31:0] val);
            case (idx)
                REG_MODE:   mode = val[1:0];
                REG_INVERT: inv = val[0];
                REG_PFACT:  pfact = val;
                default:    vfact = val;
            endcase
        endfunction

        // note one accepted request and queue what it must produce
        function void note_request(input logic cmd, input logic [15:0] pulse,
                                   input logic b, input logic [31:0] t,
                                   input logic signed [47:0] target);
            track_out_t         r;
            logic [31:0]        dt;
            logic signed [63:0] dp;
            r.stat = STAT_OK;
            if (cmd) begin
                if (pfact == 0)
                    r.stat = STAT_PF_ZERO;
                else
                    pos = divide(64'(target), pfact);
            end
            else begin
                if (mode == MODE_QUAD)
                    pos = clamp48((b ^ inv) ? pos + 65536 : pos - 65536);
                else
                    pos = (($signed({48'd0, pulse}) - 64'sd1) * 64'sd65536) / 64'sd1023;
                dt = t - prev_t;
                if (dt == 0)
                    r.stat = STAT_DT_ZERO;
                else begin
                    dp = (pos - prev_pos) * 1000;
                    vel = clamp48(dp / $signed({32'd0, dt}));
                end
                prev_pos = pos;
                prev_t = t;
            end
            r.spos = 48'(scale(pos, pfact));
            r.svel = 48'(scale(vel, vfact));
            pending.push_back(r);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(input logic signed [47:0] spos,
                                   input logic signed [47:0] svel, input logic [1:0] st);
            track_out_t e;
            if (pending.size() == 0) begin
                $error("unexpected result pos=%0d vel=%0d status=%0d", spos, svel, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (spos !== e.spos) begin
                $error("scaled_position expected %0d actual %0d", e.spos, spos);
                errors++;
            end
            if (svel !== e.svel) begin
                $error("scaled_velocity expected %0d actual %0d", e.svel, svel);
                errors++;
            end
            if (st !== e.stat) begin
                $error("status expected %0d actual %0d", e.stat, st);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_write = 0;
    logic [1:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;

    evt_in_if  in_ch();
    evt_out_if out_ch();

    encoder_position_velocity_tracker dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #10 clk = ~clk;

    track_board board;
    logic [31:0] now_ms;     // running timestamp of the stimulus
    bit          hold_off;   // long receiver stall requested
    int          idle_cycles;

    // receiver: stall pattern of its own, plus long hold-offs in one random phase
    initial
    begin
        int phase;
        phase = 0;
        out_ch.ready = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            phase++;
            if (hold_off)
                out_ch.ready <= 0;
            else if ((phase / 300) % 2 == 0)
                out_ch.ready <= 1;         // stretch with no stalls
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // take results at the edge, check with the scoreboard
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.scaled_position, out_ch.scaled_velocity,
                               out_ch.status);

    // watchdog: cycles with no accepted request on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("timeout");
            $display("tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
        board.configure(idx, val);
    endtask

    // offer one request, hold valid until accepted; valid stays up if more follow
    task automatic send(input logic cmd, input logic [15:0] pulse, input logic b,
                        input logic [31:0] t, input logic signed [47:0] target,
                        input bit keep);
        in_ch.valid <= 1;
        in_ch.command <= cmd;
        in_ch.pulse_high_us <= pulse;
        in_ch.b_level <= b;
        in_ch.time_ms <= t;
        in_ch.new_position <= target;
        do @(posedge clk); while (!in_ch.ready);
        board.note_request(cmd, pulse, b, t, target);
        if (!keep) begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
    endtask

    // idle point: everything back, then latency margin before a config write
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_factor();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return $signed(32'($urandom_range(0, 262144)) - 32'd131072);
            default: return $signed($urandom());
        endcase
    endfunction

    // random time step: mostly small, sometimes zero, sometimes wrapping
    function automatic logic [31:0] next_time();
        case ($urandom_range(0, 9))
            0: return now_ms;
            1: return $urandom();
            2: return now_ms + 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return now_ms + $urandom_range(1, 50);
        endcase
    endfunction

    function automatic logic signed [47:0] rand_target();
        case ($urandom_range(0, 4))
            0: return {1'b0, {47{1'b1}}};
            1: return {1'b1, 47'd0};
            2: return $signed(48'($urandom_range(0, 2000000)) - 48'd1000000);
            default: return {$urandom(), 16'($urandom())};
        endcase
    endfunction

    // random burst: mostly sample updates, some set-position
    task automatic random_burst(input int count);
        logic        cmd;
        logic [15:0] pulse;
        int          k;
        for (k = 0; k < count; k++) begin
            cmd = ($urandom_range(0, 5) == 0);
            pulse = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                 : 16'($urandom_range(0, 1100));
            now_ms = next_time();
            send(cmd, pulse, 1'($urandom_range(0, 1)), now_ms, rand_target(),
                 k != count - 1);
        end
    endtask

    initial
    begin
        int phase_no;
        int sent;
        int n;
        in_ch.valid = 0;
        in_ch.command = 0;
        in_ch.pulse_high_us = 0;
        in_ch.b_level = 0;
        in_ch.time_ms = 0;
        in_ch.new_position = 0;
        board = new();
        now_ms = 0;
        hold_off = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed: reset config, pwm extremes, zero dt, wrap
        send(1'b0, 16'd0, 1'b0, 32'd0, 48'sd0, 1'b0);          // pulse zero, zero elapsed
        send(1'b0, 16'd1, 1'b0, 32'd1, 48'sd0, 1'b0);
        send(1'b0, 16'd1024, 1'b0, 32'd2, 48'sd0, 1'b0);
        send(1'b0, 16'hFFFF, 1'b1, 32'd3, 48'sd0, 1'b0);
        send(1'b0, 16'd512, 1'b0, 32'hFFFF_FFFF, 48'sd0, 1'b0); // timer wrap
        send(1'b0, 16'd10, 1'b0, 32'd5, 48'sd0, 1'b0);
        send(1'b1, 16'd0, 1'b0, 32'd0, {1'b0, {47{1'b1}}}, 1'b0);
        send(1'b1, 16'd0, 1'b0, 32'hFFFF_FFFF, {1'b1, 47'd0}, 1'b0);
        drain();
        write_reg(REG_MODE, 32'd1);
        write_reg(REG_INVERT, 32'd0);
        send(1'b0, 16'd0, 1'b1, 32'd6, 48'sd0, 1'b0);
        send(1'b0, 16'd0, 1'b0, 32'd6, 48'sd0, 1'b0);          // quad step, zero dt
        send(1'b0, 16'd0, 1'b1, 32'd7, 48'sd0, 1'b0);
        drain();
        write_reg(REG_INVERT, 32'd1);
        write_reg(REG_PFACT, 32'h7FFF_FFFF);
        write_reg(REG_VFACT, 32'h8000_0000);
        send(1'b0, 16'd0, 1'b1, 32'd100, 48'sd0, 1'b0);
        send(1'b0, 16'd0, 1'b0, 32'd101, 48'sd0, 1'b0);
        send(1'b1, 16'd0, 1'b0, 32'd0, {1'b0, {47{1'b1}}}, 1'b0);
        send(1'b0, 16'd0, 1'b0, 32'd102, 48'sd0, 1'b0);        // quad step after setting the largest target
        drain();
        write_reg(REG_PFACT, 32'd0);
        write_reg(REG_MODE, 32'd3);                           // unused mode acts as pwm
        send(1'b1, 16'd0, 1'b0, 32'd0, 48'sd12345, 1'b0);     // zero factor holds position
        send(1'b0, 16'd700, 1'b0, 32'd200, 48'sd0, 1'b0);
        send(1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, -48'sd1, 1'b0);
        drain();
        write_reg(REG_MODE, 32'd2);
        write_reg(REG_PFACT, 32'h8000_0000);
        write_reg(REG_VFACT, 32'h7FFF_FFFF);
        send(1'b1, 16'd0, 1'b0, 32'd0, {1'b1, 47'd0}, 1'b0);
        send(1'b0, 16'd1, 1'b0, 32'd300, 48'sd0, 1'b0);
        drain();

        // random phases with new settings between them
        sent = 0;
        phase_no = 0;
        while (sent < 1630) begin
            write_reg(REG_MODE, 32'($urandom_range(0, 3)));
            write_reg(REG_INVERT, 32'($urandom_range(0, 1)));
            write_reg(REG_PFACT, rand_factor());
            write_reg(REG_VFACT, rand_factor());
            repeat (8) begin
                n = $urandom_range(1, 12);
                if (phase_no == 2)
                    fork
                        begin
                            hold_off = 1;
                            repeat (3000) @(posedge clk);
                            hold_off = 0;
                        end
                    join_none
                random_burst(n);
                sent += n;
                repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 150)) @(posedge clk);
            end
            phase_no++;
            drain();
        end

        drain();
        $display("covered %0d checked results over %0d random phases, all modes and factor extremes",
                 board.checked, phase_no);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/evt_pkg.sv
rtl/evt_if.sv
rtl/evt_div.sv
rtl/evt_dp.sv
rtl/evt_ctrl.sv
rtl/encoder_position_velocity_tracker.sv
test/tb.sv
